[sv/fsp_pkg.sv]
package fsp_pkg;

	localparam int unsigned WidthW  = 31;
	localparam int unsigned PrecW   = 32;
	localparam int unsigned CountW  = 2;
	localparam int unsigned CharW   = 8;
	localparam int unsigned StarW   = 32;
	localparam int unsigned InDataW = 40;
	localparam int unsigned OutDataW = 88;

	localparam logic [WidthW-1:0] SAT_MAX = {WidthW{1'b1}};
	localparam logic [CountW-1:0] CNT_MAX = {CountW{1'b1}};

	localparam logic [CharW-1:0] CH_HASH  = 8'h23;
	localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
	localparam logic [CharW-1:0] CH_NINE  = 8'h39;
	localparam logic [CharW-1:0] CH_MINUS = 8'h2D;
	localparam logic [CharW-1:0] CH_SPACE = 8'h20;
	localparam logic [CharW-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CharW-1:0] CH_STAR  = 8'h2A;
	localparam logic [CharW-1:0] CH_DOT   = 8'h2E;
	localparam logic [CharW-1:0] CH_LONG  = 8'h6C;
	localparam logic [CharW-1:0] CH_SHORT = 8'h68;

	typedef enum logic [2:0] {
		PH_FLAGS   = 3'd0,
		PH_WDIGITS = 3'd1,
		PH_AFTER_W = 3'd2,
		PH_DOT     = 3'd3,
		PH_AFTER_P = 3'd4,
		PH_LONGS   = 3'd5,
		PH_SHORTS  = 3'd6,
		PH_PDIGITS = 3'd7
	} phase_t;

	typedef struct packed {
		logic plus;
		logic space;
		logic left;
		logic zero;
		logic alt;
	} flags_t;

	typedef struct packed {
		phase_t                   phase;
		flags_t                   flags;
		logic [WidthW-1:0]        width;
		logic signed [PrecW-1:0]  prec;
		logic                     prec_seen;
		logic [CountW-1:0]        longs;
		logic [CountW-1:0]        shorts;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase: PH_FLAGS, flags: '0, width: '0, prec: '0,
		prec_seen: 1'b0, longs: '0, shorts: '0
	};

	typedef struct packed {
		logic [CharW-1:0]         stop_char;
		logic [CountW-1:0]        short_count;
		logic [CountW-1:0]        long_count;
		logic signed [PrecW-1:0]  precision_value;
		logic                     precision_given;
		logic [WidthW-1:0]        field_width;
		flags_t                   flags;
	} result_t;

	function automatic logic [WidthW-1:0] mul10_sat(input logic [WidthW-1:0] acc,
			input logic [3:0] dig);
		logic [WidthW+3:0] v;
		v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{WidthW{1'b0}}, dig};
		return (v > {4'b0, SAT_MAX}) ? SAT_MAX : v[WidthW-1:0];
	endfunction

	function automatic logic [CountW-1:0] inc_sat(input logic [CountW-1:0] n);
		return (n == CNT_MAX) ? CNT_MAX : n + 1'b1;
	endfunction

endpackage

[sv/fsp_step.sv]
module fsp_step (
	input  fsp_pkg::state_t                 st,
	input  logic [fsp_pkg::CharW-1:0]       spec_char,
	input  logic signed [fsp_pkg::StarW-1:0] star_value,
	output fsp_pkg::state_t                 nxt,
	output logic                            stop,
	output fsp_pkg::result_t                res
);

	logic                           is_digit;
	logic [3:0]                     dval;
	logic [fsp_pkg::CharW-1:0]      dsub;
	logic                           is_star;
	logic                           is_dot;
	logic                           is_l;
	logic                           is_h;
	fsp_pkg::flags_t                fbit;
	logic [fsp_pkg::StarW-1:0]      mag;
	logic                           take_aw;
	logic                           take_sz;
	fsp_pkg::flags_t                fout;

	assign is_digit = (spec_char >= fsp_pkg::CH_ZERO) && (spec_char <= fsp_pkg::CH_NINE);
	assign dsub     = spec_char - fsp_pkg::CH_ZERO;
	assign dval     = dsub[3:0];
	assign is_star  = (spec_char == fsp_pkg::CH_STAR);
	assign is_dot   = (spec_char == fsp_pkg::CH_DOT);
	assign is_l     = (spec_char == fsp_pkg::CH_LONG);
	assign is_h     = (spec_char == fsp_pkg::CH_SHORT);
	assign mag      = 32'd0 - star_value;

	always_comb begin
		fbit = '0;
		case (spec_char)
			fsp_pkg::CH_HASH:  fbit.alt   = 1'b1;
			fsp_pkg::CH_ZERO:  fbit.zero  = 1'b1;
			fsp_pkg::CH_MINUS: fbit.left  = 1'b1;
			fsp_pkg::CH_SPACE: fbit.space = 1'b1;
			fsp_pkg::CH_PLUS:  fbit.plus  = 1'b1;
			default:           fbit       = '0;
		endcase
	end

	always_comb begin
		nxt     = st;
		stop    = 1'b0;
		take_aw = 1'b0;
		take_sz = 1'b0;
		unique case (st.phase)
			fsp_pkg::PH_FLAGS: begin
				if (fbit != '0) begin
					nxt.flags = st.flags | fbit;
				end else if (is_star) begin
					if (star_value[fsp_pkg::StarW-1]) begin
						nxt.flags.left = 1'b1;
						nxt.width = mag[fsp_pkg::StarW-1] ? fsp_pkg::SAT_MAX
							: mag[fsp_pkg::WidthW-1:0];
					end else begin
						nxt.width = star_value[fsp_pkg::WidthW-1:0];
					end
					nxt.phase = fsp_pkg::PH_AFTER_W;
				end else if (is_digit) begin
					nxt.width = {{(fsp_pkg::WidthW-4){1'b0}}, dval};
					nxt.phase = fsp_pkg::PH_WDIGITS;
				end else begin
					take_aw = 1'b1;
				end
			end
			fsp_pkg::PH_WDIGITS: begin
				if (is_digit) begin
					nxt.width = fsp_pkg::mul10_sat(st.width, dval);
				end else begin
					take_aw = 1'b1;
				end
			end
			fsp_pkg::PH_AFTER_W: take_aw = 1'b1;
			fsp_pkg::PH_DOT: begin
				if (is_star) begin
					nxt.prec  = star_value;
					nxt.phase = fsp_pkg::PH_AFTER_P;
				end else if (is_digit) begin
					nxt.prec  = {{(fsp_pkg::PrecW-4){1'b0}}, dval};
					nxt.phase = fsp_pkg::PH_PDIGITS;
				end else begin
					nxt.prec  = '0;
					nxt.phase = fsp_pkg::PH_AFTER_P;
					take_sz   = 1'b1;
				end
			end
			fsp_pkg::PH_PDIGITS: begin
				if (is_digit) begin
					nxt.prec = {1'b0, fsp_pkg::mul10_sat(st.prec[fsp_pkg::WidthW-1:0], dval)};
				end else begin
					take_sz = 1'b1;
				end
			end
			fsp_pkg::PH_AFTER_P: take_sz = 1'b1;
			fsp_pkg::PH_LONGS: begin
				if (is_l) begin
					nxt.longs = fsp_pkg::inc_sat(st.longs);
				end else if (is_h) begin
					nxt.shorts = fsp_pkg::inc_sat(st.shorts);
					nxt.phase  = fsp_pkg::PH_SHORTS;
				end else begin
					stop = 1'b1;
				end
			end
			fsp_pkg::PH_SHORTS: begin
				if (is_h) begin
					nxt.shorts = fsp_pkg::inc_sat(st.shorts);
				end else begin
					stop = 1'b1;
				end
			end
		endcase

		if (take_aw && is_dot) begin
			nxt.prec_seen = 1'b1;
			nxt.prec      = '0;
			nxt.phase     = fsp_pkg::PH_DOT;
		end else if ((take_aw || take_sz) && is_l) begin
			nxt.longs = fsp_pkg::inc_sat(st.longs);
			nxt.phase = fsp_pkg::PH_LONGS;
		end else if ((take_aw || take_sz) && is_h) begin
			nxt.shorts = fsp_pkg::inc_sat(st.shorts);
			nxt.phase  = fsp_pkg::PH_SHORTS;
		end else if (take_aw || take_sz) begin
			stop = 1'b1;
		end
	end

	always_comb begin
		fout = st.flags;
		if (fout.left) begin
			fout.zero = 1'b0;
		end
		if (fout.plus) begin
			fout.space = 1'b0;
		end
		res.flags           = fout;
		res.field_width     = st.width;
		res.precision_given = st.prec_seen;
		res.precision_value = st.prec_seen ? st.prec : '0;
		res.long_count      = st.longs;
		res.short_count     = st.shorts;
		res.stop_char       = spec_char;
	end

endmodule

[sv/format_spec_parser_core.sv]
// channel | dir | fields (tdata, lowest bit first)
// s_      | in  | spec_char[7:0], star_value[39:8]
// m_      | out | flag_alternate, flag_zero_pad, flag_left, flag_space, flag_plus,
//         |     | field_width[35:5], precision_given[36], precision_value[68:37],
//         |     | long_count[70:69], short_count[72:71], stop_char[80:73]
//
// One byte a cycle unless a stop byte waits on the result register; a stop byte
// passes from the input stage into the result register, with the parser state updated from the input stage.
// arst_n clears the parser state and both valid flags at once.
// While a result waits on m_tready, bytes that are not stop bytes keep flowing;
// a stop byte holds in the input stage until the result register frees.
module format_spec_parser_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [fsp_pkg::InDataW-1:0]     s_tdata,  // spec_char, star_value
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [fsp_pkg::OutDataW-1:0]    m_tdata   // flags x5, field_width,
	                                                  // precision_given, precision_value,
	                                                  // long_count, short_count, stop_char
);

	logic                                 valid_s1;
	logic [fsp_pkg::CharW-1:0]            char_s1;
	logic signed [fsp_pkg::StarW-1:0]     star_s1;
	fsp_pkg::state_t                      st_q;
	fsp_pkg::state_t                      nxt;
	logic                                 stop;
	fsp_pkg::result_t                     res;
	fsp_pkg::result_t                     res_q;
	logic                                 out_valid_q;
	logic                                 adv;

	fsp_step u_step (
		.st         (st_q),
		.spec_char  (char_s1),
		.star_value (star_s1),
		.nxt        (nxt),
		.stop       (stop),
		.res        (res)
	);

	assign adv      = valid_s1 && (!stop || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(fsp_pkg::OutDataW - $bits(fsp_pkg::result_t)){1'b0}}, res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata[fsp_pkg::CharW-1:0];
			star_s1 <= s_tdata[fsp_pkg::CharW +: fsp_pkg::StarW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= fsp_pkg::STATE_RESET;
		end else if (adv) begin
			st_q <= stop ? fsp_pkg::STATE_RESET : nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && stop) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && stop) begin
			res_q <= res;
		end
	end

	a_emit_resets: assert property (@(posedge clk) disable iff (!arst_n)
		adv && stop |=> st_q == fsp_pkg::STATE_RESET)
		else $error("parser state not cleared after a result");

	a_rose_from_stop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv && stop))
		else $error("result raised without a stop byte");

	a_shorts_phase: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.shorts != '0 |-> st_q.phase == fsp_pkg::PH_SHORTS)
		else $error("short count set outside the shorts phase");

	a_prec_unseen: assert property (@(posedge clk) disable iff (!arst_n)
		!st_q.prec_seen |-> st_q.prec == '0)
		else $error("precision held without a dot");

endmodule
